// ===== rtl/msr_pkg.sv =====
// ----------------------------------------------------------------------------
// msr_pkg: shared types and constants for the motor soft-start ramp controller
// Widths, mode codes, command characters and register reset values.
// ----------------------------------------------------------------------------
package msr_pkg;

    localparam int DUTY_W   = 14;
    localparam int RTIMER_W = 8;
    localparam int BTIMER_W = 16;
    localparam int MODE_W   = 2;
    localparam int CMD_W    = 8;

    typedef logic [DUTY_W-1:0]   duty_t;
    typedef logic [RTIMER_W-1:0] rtimer_t;
    typedef logic [BTIMER_W-1:0] btimer_t;
    typedef logic [MODE_W-1:0]   mode_t;
    typedef logic [CMD_W-1:0]    cmd_t;

    // highest duty the timer compare may take, bounded by the field width
    localparam int unsigned DUTY_MAX     = 9000;
    localparam int unsigned DUTY_W_MAX   = (1 << DUTY_W) - 1;
    localparam int unsigned DUTY_LIMIT_I = (DUTY_MAX < DUTY_W_MAX) ? DUTY_MAX : DUTY_W_MAX;
    localparam duty_t       DUTY_LIMIT   = DUTY_W'(DUTY_LIMIT_I);

    localparam mode_t MODE_STOP = 2'd0;
    localparam mode_t MODE_FWD  = 2'd1;
    localparam mode_t MODE_REV  = 2'd2;

    localparam cmd_t CMD_FWD_LC  = 8'h69; // 'i'
    localparam cmd_t CMD_FWD_UC  = 8'h49; // 'I'
    localparam cmd_t CMD_REV_LC  = 8'h67; // 'g'
    localparam cmd_t CMD_REV_UC  = 8'h47; // 'G'
    localparam cmd_t CMD_STOP_LC = 8'h64; // 'd'
    localparam cmd_t CMD_STOP_UC = 8'h44; // 'D'

    // configuration register indexes
    localparam logic [1:0] REG_STEP_SIZE   = 2'd0;
    localparam logic [1:0] REG_RAMP_PERIOD = 2'd1;
    localparam logic [1:0] REG_RUN_SPEED   = 2'd2;
    localparam logic [1:0] REG_BUZZ_PERIOD = 2'd3;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam duty_t   STEP_SIZE_RST   = 14'd50;
    localparam rtimer_t RAMP_PERIOD_RST = 8'd10;
    localparam duty_t   RUN_SPEED_RST   = 14'd4500;
    localparam btimer_t BUZZ_PERIOD_RST = 16'd500;

endpackage

// ===== rtl/motor_soft_start_ramp_controller_top.sv =====
// ----------------------------------------------------------------------------
// motor_soft_start_ramp_controller_top: PWM soft-start ramp with run button
// One item per millisecond tick; returns duty, direction, state and buzzer.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata fields (lsb first)                     | width
//  s_       | in  | cmd_valid, cmd_byte[7:0], run_pressed        | 16
//  m_       | out | pwm_duty[13:0], dir_level, run_state[1:0],   | 24
//           |     | buzzer_level                                 |
//  cfg_     | in  | register write, index 0..3                   | 16
//
// one item per clock unless the result stalls: an accepted item updates the
// controller state in the same cycle and its result appears in the output
// register on the next cycle. the input side stays ready while the output
// register is empty or being taken, so a stalled result holds the input back
// by one register only. synchronous active-low reset restores the register
// defaults and a stopped motor.
// ----------------------------------------------------------------------------
module motor_soft_start_ramp_controller_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // cmd_valid, cmd_byte[7:0], run_pressed, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // pwm_duty[13:0], dir_level, run_state[1:0],
                                   // buzzer_level, zero pad
    input  logic                                cfg_wr_en,
    input  logic [msr_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [msr_pkg::CFG_DATA_W-1:0]      cfg_wr_data
);
    import msr_pkg::*;

    // configuration
    duty_t   step_size_reg;
    rtimer_t ramp_period_reg;
    duty_t   run_speed_reg;
    btimer_t buzz_period_reg;

    // controller state
    duty_t   duty_now_reg,    duty_now_next;
    duty_t   duty_goal_reg,   duty_goal_next;
    mode_t   goal_mode_reg,   goal_mode_next;
    duty_t   goal_speed_reg,  goal_speed_next;
    mode_t   actual_mode_reg, actual_mode_next;
    logic    dir_reg,         dir_next;
    logic    button_prev_reg;
    rtimer_t ramp_timer_reg,  ramp_timer_next;
    btimer_t buzz_timer_reg,  buzz_timer_next;
    logic    buzz_reg,        buzz_next;

    logic    out_valid_reg;
    logic [23:0] out_data_reg;

    logic    accept;
    logic    in_cmd_valid;
    cmd_t    in_cmd_byte;
    logic    in_pressed;
    rtimer_t ramp_count;
    btimer_t buzz_count;
    logic    ramp_fire;
    duty_t   duty_stepped;
    duty_t   speed_sat;

    assign in_cmd_valid = s_tdata[0];
    assign in_cmd_byte  = s_tdata[8:1];
    assign in_pressed   = s_tdata[9];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // saturating tick counters
    assign ramp_count = (ramp_timer_reg == '1) ? ramp_timer_reg : ramp_timer_reg + 1'b1;
    assign buzz_count = (buzz_timer_reg == '1) ? buzz_timer_reg : buzz_timer_reg + 1'b1;
    assign ramp_fire  = (ramp_count >= ramp_period_reg);
    assign speed_sat  = (run_speed_reg > DUTY_LIMIT) ? DUTY_LIMIT : run_speed_reg;

    msr_ramp u_ramp (
        .duty_now     (duty_now_reg),
        .duty_goal    (duty_goal_reg),
        .step_size    (step_size_reg),
        .duty_stepped (duty_stepped)
    );

    always_comb begin
        duty_now_next    = duty_now_reg;
        duty_goal_next   = duty_goal_reg;
        goal_mode_next   = goal_mode_reg;
        goal_speed_next  = goal_speed_reg;
        actual_mode_next = actual_mode_reg;
        dir_next         = dir_reg;
        ramp_timer_next  = ramp_count;
        buzz_timer_next  = buzz_count;
        buzz_next        = buzz_reg;

        // ramp update on the period boundary
        if (ramp_fire) begin
            ramp_timer_next = '0;
            duty_now_next   = duty_stepped;
            if (duty_stepped == '0) begin
                actual_mode_next = MODE_STOP;
            end
        end

        // command decode; unknown bytes keep the target
        if (in_cmd_valid) begin
            case (in_cmd_byte)
                CMD_FWD_LC, CMD_FWD_UC: begin
                    goal_mode_next  = MODE_FWD;
                    goal_speed_next = speed_sat;
                end
                CMD_REV_LC, CMD_REV_UC: begin
                    goal_mode_next  = MODE_REV;
                    goal_speed_next = speed_sat;
                end
                CMD_STOP_LC, CMD_STOP_UC: begin
                    goal_mode_next  = MODE_STOP;
                    goal_speed_next = '0;
                end
                default: begin
                end
            endcase
        end

        // press applies the target, a command while held re-applies it, release clears the goal
        if ((in_pressed && (in_pressed != button_prev_reg)) || (in_cmd_valid && in_pressed)) begin
            if (goal_mode_next == MODE_FWD) begin
                dir_next = 1'b1;
            end else if (goal_mode_next == MODE_REV) begin
                dir_next = 1'b0;
            end
            duty_goal_next = goal_speed_next;
            if (goal_mode_next != MODE_STOP) begin
                actual_mode_next = goal_mode_next;
            end
        end else if (!in_pressed && button_prev_reg) begin
            duty_goal_next = '0;
        end

        // buzzer toggles only while reversing with the button held
        if (actual_mode_next == MODE_REV && in_pressed) begin
            if (buzz_count >= buzz_period_reg) begin
                buzz_next       = !buzz_reg;
                buzz_timer_next = '0;
            end
        end else begin
            buzz_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_size_reg   <= STEP_SIZE_RST;
            ramp_period_reg <= RAMP_PERIOD_RST;
            run_speed_reg   <= RUN_SPEED_RST;
            buzz_period_reg <= BUZZ_PERIOD_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_STEP_SIZE:   step_size_reg   <= cfg_wr_data[DUTY_W-1:0];
                REG_RAMP_PERIOD: ramp_period_reg <= cfg_wr_data[RTIMER_W-1:0];
                REG_RUN_SPEED:   run_speed_reg   <= cfg_wr_data[DUTY_W-1:0];
                REG_BUZZ_PERIOD: buzz_period_reg <= cfg_wr_data[BTIMER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            duty_now_reg    <= '0;
            duty_goal_reg   <= '0;
            goal_mode_reg   <= MODE_STOP;
            goal_speed_reg  <= '0;
            actual_mode_reg <= MODE_STOP;
            dir_reg         <= 1'b0;
            button_prev_reg <= 1'b0;
            ramp_timer_reg  <= '0;
            buzz_timer_reg  <= '0;
            buzz_reg        <= 1'b0;
        end else if (accept) begin
            duty_now_reg    <= duty_now_next;
            duty_goal_reg   <= duty_goal_next;
            goal_mode_reg   <= goal_mode_next;
            goal_speed_reg  <= goal_speed_next;
            actual_mode_reg <= actual_mode_next;
            dir_reg         <= dir_next;
            button_prev_reg <= in_pressed;
            ramp_timer_reg  <= ramp_timer_next;
            buzz_timer_reg  <= buzz_timer_next;
            buzz_reg        <= buzz_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_data_reg <= {6'd0, buzz_next, actual_mode_next, dir_next, duty_now_next};
        end
    end

    a_duty_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[DUTY_W-1:0] <= DUTY_LIMIT)
        else $error("duty above limit");

    a_buzz_reverse: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[17] |-> m_tdata[16:15] == MODE_REV)
        else $error("buzzer active outside reverse");

    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while result stalled");

endmodule

// ===== rtl/msr_ramp.sv =====
// ----------------------------------------------------------------------------
// msr_ramp: one slew step of the duty toward its goal
// Moves the duty by the step size in either direction, clamped at the goal.
// ----------------------------------------------------------------------------
module msr_ramp (
    input  msr_pkg::duty_t duty_now,
    input  msr_pkg::duty_t duty_goal,
    input  msr_pkg::duty_t step_size,
    output msr_pkg::duty_t duty_stepped
);
    import msr_pkg::*;

    logic [DUTY_W:0] sum_up;
    duty_t           diff_down;

    assign sum_up    = {1'b0, duty_now} + {1'b0, step_size};
    assign diff_down = duty_now - duty_goal;

    always_comb begin
        if (duty_now < duty_goal) begin
            duty_stepped = (sum_up > {1'b0, duty_goal}) ? duty_goal : sum_up[DUTY_W-1:0];
        end else if (duty_now > duty_goal) begin
            // clamp on the way down too
            duty_stepped = (diff_down <= step_size) ? duty_goal : (duty_now - step_size);
        end else begin
            duty_stepped = duty_now;
        end
    end

endmodule
